// ----- hw/rtl/ba_pkg.sv -----
package ba_pkg;

  localparam int unsigned MaxSlotW = 16;
  localparam int unsigned MaxCntW  = 13;
  localparam int unsigned MaxIdxW  = 12;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_UPDATE = 3'd1,
    OP_FREE   = 3'd2,
    OP_FLUSH  = 3'd3,
    OP_LOOKUP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_FREE   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_EXEC,
    F_POP,
    F_BACK,
    F_RESP
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_PRD,
    B_SRD,
    B_APPLY,
    B_LRES,
    B_DONE
  } back_state_e;

  // front to back command
  typedef struct packed {
    logic                valid;
    logic                lookup;
    logic [MaxSlotW-1:0] slot;
    logic [MaxCntW-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic        done;
    logic        bound;
    logic [31:0] texture;
    logic [31:0] sampler;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic [MaxSlotW-1:0] slot;
  } push_t;

  // pending queue write port
  typedef struct packed {
    logic                valid;
    logic [MaxIdxW-1:0]  idx;
    kind_e               kind;
    logic [MaxSlotW-1:0] slot;
    logic [31:0]         texture;
    logic [31:0]         sampler;
  } penq_t;

endpackage

// ----- hw/rtl/ba_ram.sv -----
module ba_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                       wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                       rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ba_front.sv -----
module ba_front import ba_pkg::*; #(
  parameter int unsigned SLOT_CAPACITY = 4096,
  parameter int unsigned PENDING_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [11:0] slot_i,
  input  logic [31:0] texture_i,
  input  logic [31:0] sampler_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] slot_out_o,
  output logic [1:0]  status_o,
  output logic        bound_o,
  output logic [31:0] texture_out_o,
  output logic [31:0] sampler_out_o,
  output logic [11:0] allocated_count_o,
  input  logic        init_done_i,
  input  logic [MaxSlotW-1:0] committed_i,
  output cmd_t        cmd_o,
  input  rsp_t        rsp_i,
  input  push_t       push_i,
  output penq_t       penq_o
);

  localparam int unsigned SW  = $clog2(SLOT_CAPACITY);
  localparam int unsigned PCW = $clog2(PENDING_DEPTH + 1);
  localparam logic [SW:0]    CapW   = (SW+1)'(SLOT_CAPACITY);
  localparam logic [PCW-1:0] DepthW = PCW'(PENDING_DEPTH);

  front_state_e state_q, state_d;
  logic [2:0]   op_q;
  logic [11:0]  slot_q;
  logic [31:0]  tex_q, smp_q;
  logic [SW:0]  fresh_q, fresh_d;
  logic [SW:0]  top_q, top_d;
  logic [PCW-1:0] pcount_q, pcount_d;

  logic [SW-1:0] res_slot_q, res_slot_d;
  status_e       res_status_q, res_status_d;
  logic          res_bound_q, res_bound_d;
  logic [31:0]   res_tex_q, res_tex_d, res_smp_q, res_smp_d;

  logic        out_valid_q;
  logic [11:0] out_slot_q, out_cnt_q;
  logic [1:0]  out_status_q;
  logic        out_bound_q;
  logic [31:0] out_tex_q, out_smp_q;
  logic        out_load;

  logic [SW-1:0] stk_raddr;
  logic [SW-1:0] stk_rdata;
  logic          full, slot_bad;
  logic          enq;
  kind_e         enq_kind;
  logic [SW-1:0] enq_slot;

  assign full     = pcount_q >= DepthW;
  assign slot_bad = (slot_q == 12'd0) || (32'(slot_q) >= 32'(fresh_q));

  ba_ram #(.W(SW), .D(SLOT_CAPACITY)) u_stack (
    .clk_i   (clk_i),
    .we_i    (push_i.valid && (top_q < CapW)),
    .waddr_i (top_q[SW-1:0]),
    .wdata_i (push_i.slot[SW-1:0]),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    state_d      = state_q;
    fresh_d      = fresh_q;
    top_d        = top_q;
    pcount_d     = pcount_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    res_bound_d  = res_bound_q;
    res_tex_d    = res_tex_q;
    res_smp_d    = res_smp_q;
    stk_raddr    = top_q[SW-1:0] - SW'(1);
    enq          = 1'b0;
    enq_kind     = KIND_ALLOC;
    enq_slot     = SW'(slot_q);
    cmd_o        = '0;
    out_load     = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i && init_done_i) begin
          res_slot_d   = '0;
          res_status_d = ST_OK;
          res_bound_d  = 1'b0;
          res_tex_d    = '0;
          res_smp_d    = '0;
          state_d      = F_EXEC;
        end
      end
      F_EXEC: begin
        state_d = F_RESP;
        case (op_q)
          OP_ALLOC: begin
            if (full) begin
              res_status_d = ST_FULL;
            end else if (top_q != '0) begin
              top_d   = top_q - (SW+1)'(1);
              state_d = F_POP;
            end else if (fresh_q >= CapW) begin
              res_status_d = ST_NO_FREE;
            end else begin
              res_slot_d = fresh_q[SW-1:0];
              enq_slot   = fresh_q[SW-1:0];
              enq        = 1'b1;
              fresh_d    = fresh_q + (SW+1)'(1);
            end
          end
          OP_UPDATE, OP_FREE: begin
            if (slot_bad) begin
              res_status_d = ST_INVALID;
            end else if (full) begin
              res_status_d = ST_FULL;
            end else begin
              enq      = 1'b1;
              enq_kind = (op_q == OP_UPDATE) ? KIND_UPDATE : KIND_FREE;
            end
          end
          OP_FLUSH: begin
            cmd_o.valid = 1'b1;
            cmd_o.count = MaxCntW'(pcount_q);
            state_d     = F_BACK;
          end
          OP_LOOKUP: begin
            if (slot_q == 12'd0 || 32'(slot_q) >= 32'(SLOT_CAPACITY)) begin
              res_status_d = ST_INVALID;
            end else begin
              cmd_o.valid  = 1'b1;
              cmd_o.lookup = 1'b1;
              cmd_o.slot   = MaxSlotW'(slot_q);
              state_d      = F_BACK;
            end
          end
          default: res_status_d = ST_INVALID;
        endcase
      end
      F_POP: begin
        res_slot_d = stk_rdata;
        enq_slot   = stk_rdata;
        enq        = 1'b1;
        state_d    = F_RESP;
      end
      F_BACK: begin
        if (rsp_i.done) begin
          res_bound_d = rsp_i.bound;
          res_tex_d   = rsp_i.texture;
          res_smp_d   = rsp_i.sampler;
          if (op_q == OP_FLUSH) begin
            pcount_d = '0;
          end
          state_d = F_RESP;
        end
      end
      F_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
    if (enq) begin
      pcount_d = pcount_q + PCW'(1);
    end
    // frees during a flush return slots to the stack
    if (push_i.valid && (top_q < CapW)) begin
      top_d = top_q + (SW+1)'(1);
    end
  end

  always_comb begin
    penq_o         = '0;
    penq_o.valid   = enq;
    penq_o.idx     = MaxIdxW'(pcount_q);
    penq_o.kind    = enq_kind;
    penq_o.slot    = MaxSlotW'(enq_slot);
    penq_o.texture = (enq_kind == KIND_UPDATE) ? tex_q : 32'd0;
    penq_o.sampler = (enq_kind == KIND_UPDATE) ? smp_q : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      fresh_q     <= (SW+1)'(1);
      top_q       <= '0;
      pcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fresh_q  <= fresh_d;
      top_q    <= top_d;
      pcount_q <= pcount_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i && init_done_i) begin
      op_q   <= op_i;
      slot_q <= slot_i;
      tex_q  <= texture_i;
      smp_q  <= sampler_i;
    end
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    res_bound_q  <= res_bound_d;
    res_tex_q    <= res_tex_d;
    res_smp_q    <= res_smp_d;
    if (out_load) begin
      out_slot_q   <= 12'(res_slot_q);
      out_status_q <= res_status_q;
      out_bound_q  <= res_bound_q;
      out_tex_q    <= res_tex_q;
      out_smp_q    <= res_smp_q;
      out_cnt_q    <= 12'(committed_i);
    end
  end

  assign in_ready_o        = (state_q == F_IDLE) && init_done_i;
  assign out_valid_o       = out_valid_q;
  assign slot_out_o        = out_slot_q;
  assign status_o          = out_status_q;
  assign bound_o           = out_bound_q;
  assign texture_out_o     = out_tex_q;
  assign sampler_out_o     = out_smp_q;
  assign allocated_count_o = out_cnt_q;

endmodule

// ----- hw/rtl/ba_back.sv -----
module ba_back import ba_pkg::*; #(
  parameter int unsigned SLOT_CAPACITY = 4096,
  parameter int unsigned PENDING_DEPTH = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  penq_t penq_i,
  output rsp_t  rsp_o,
  output push_t push_o,
  output logic  init_done_o,
  output logic [MaxSlotW-1:0] committed_o
);

  localparam int unsigned SW  = $clog2(SLOT_CAPACITY);
  localparam int unsigned PCW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned EW  = 2 + SW + 64;

  back_state_e   state_q, state_d;
  logic [SW-1:0] clr_q, clr_d;
  logic [PCW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic [SW-1:0] cc_q, cc_d;
  logic [EW-1:0] ent_q;
  logic          rbound_q, rbound_d;
  logic [31:0]   rtex_q, rtex_d, rsmp_q, rsmp_d;

  logic [EW-1:0] pend_wdata, pend_rdata;
  logic [1:0]    map_wdata, map_rdata;
  logic          map_we, tab_we;
  logic [SW-1:0] map_waddr, map_raddr;
  logic [63:0]   tab_rdata;
  kind_e         ent_kind;
  logic [SW-1:0] ent_slot;
  logic          alloc_bit, bind_bit;

  assign pend_wdata = {penq_i.kind, penq_i.slot[SW-1:0], penq_i.texture, penq_i.sampler};
  assign ent_kind   = kind_e'(ent_q[EW-1 -: 2]);
  assign ent_slot   = ent_q[SW+63:64];
  assign alloc_bit  = map_rdata[1];
  assign bind_bit   = map_rdata[0];

  ba_ram #(.W(EW), .D(PENDING_DEPTH)) u_pend (
    .clk_i   (clk_i),
    .we_i    (penq_i.valid),
    .waddr_i (PIW'(penq_i.idx)),
    .wdata_i (pend_wdata),
    .raddr_i (PIW'(idx_q)),
    .rdata_o (pend_rdata)
  );

  // allocated bit above binding valid bit
  ba_ram #(.W(2), .D(SLOT_CAPACITY)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  ba_ram #(.W(64), .D(SLOT_CAPACITY)) u_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (ent_slot),
    .wdata_i (ent_q[63:0]),
    .raddr_i (map_raddr),
    .rdata_o (tab_rdata)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    cc_d      = cc_q;
    rbound_d  = rbound_q;
    rtex_d    = rtex_q;
    rsmp_d    = rsmp_q;
    map_we    = 1'b0;
    map_waddr = ent_slot;
    map_wdata = map_rdata;
    map_raddr = cmd_i.slot[SW-1:0];
    tab_we    = 1'b0;
    push_o    = '0;
    rsp_o     = '0;
    case (state_q)
      B_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = 2'b00;
        clr_d     = clr_q + SW'(1);
        if (clr_q == SW'(SLOT_CAPACITY - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (cmd_i.valid) begin
          if (cmd_i.lookup) begin
            state_d = B_LRES;
          end else begin
            idx_d    = '0;
            cnt_d    = PCW'(cmd_i.count);
            rbound_d = 1'b0;
            rtex_d   = '0;
            rsmp_d   = '0;
            state_d  = (cmd_i.count == '0) ? B_DONE : B_PRD;
          end
        end
      end
      B_PRD: state_d = B_SRD;
      B_SRD: begin
        map_raddr = pend_rdata[SW+63:64];
        state_d   = B_APPLY;
      end
      B_APPLY: begin
        case (ent_kind)
          KIND_ALLOC: begin
            if (!alloc_bit) begin
              map_we    = 1'b1;
              map_wdata = {1'b1, bind_bit};
              cc_d      = cc_q + SW'(1);
            end
          end
          KIND_UPDATE: begin
            if (alloc_bit) begin
              map_we    = 1'b1;
              map_wdata = 2'b11;
              tab_we    = 1'b1;
            end
          end
          KIND_FREE: begin
            if (alloc_bit) begin
              map_we      = 1'b1;
              map_wdata   = 2'b00;
              push_o.valid = 1'b1;
              push_o.slot  = MaxSlotW'(ent_slot);
              if (cc_q != '0) begin
                cc_d = cc_q - SW'(1);
              end
            end
          end
          default: ;
        endcase
        idx_d   = idx_q + PCW'(1);
        state_d = (idx_q + PCW'(1) == cnt_q) ? B_DONE : B_PRD;
      end
      B_LRES: begin
        rbound_d = alloc_bit && bind_bit;
        rtex_d   = (alloc_bit && bind_bit) ? tab_rdata[63:32] : 32'd0;
        rsmp_d   = (alloc_bit && bind_bit) ? tab_rdata[31:0] : 32'd0;
        state_d  = B_DONE;
      end
      B_DONE: begin
        rsp_o.done    = 1'b1;
        rsp_o.bound   = rbound_q;
        rsp_o.texture = rtex_q;
        rsp_o.sampler = rsmp_q;
        state_d       = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      cc_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      cc_q    <= cc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rbound_q <= rbound_d;
    rtex_q   <= rtex_d;
    rsmp_q   <= rsmp_d;
    if (state_q == B_SRD) begin
      ent_q <= pend_rdata;
    end
  end

  assign init_done_o = (state_q != B_CLEAR);
  assign committed_o = MaxSlotW'(cc_q);

endmodule

// ----- hw/rtl/bindless_slot_allocator_deferred.sv -----
// allocate from the free stack adds a stack read before the response; lookup reads the slot map
//   and table in the back end
// flush: each pending entry reads the queue, then the slot map, then writes
// one transfer in flight at a time; a new one is taken while the last result waits
// reset: asynchronous active low; a clearing pass sweeps every entry of the slot map,
//   no input is taken until it ends
module bindless_slot_allocator_deferred import ba_pkg::*; #(
  parameter int unsigned SLOT_CAPACITY = 4096,
  parameter int unsigned PENDING_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [11:0] slot_i,
  input  logic [31:0] texture_i,
  input  logic [31:0] sampler_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] slot_out_o,
  output logic [1:0]  status_o,
  output logic        bound_o,
  output logic [31:0] texture_out_o,
  output logic [31:0] sampler_out_o,
  output logic [11:0] allocated_count_o
);

  cmd_t  cmd;
  rsp_t  rsp;
  push_t push;
  penq_t penq;
  logic  init_done;
  logic [MaxSlotW-1:0] committed;

  ba_front #(.SLOT_CAPACITY(SLOT_CAPACITY), .PENDING_DEPTH(PENDING_DEPTH)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .slot_i            (slot_i),
    .texture_i         (texture_i),
    .sampler_i         (sampler_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .slot_out_o        (slot_out_o),
    .status_o          (status_o),
    .bound_o           (bound_o),
    .texture_out_o     (texture_out_o),
    .sampler_out_o     (sampler_out_o),
    .allocated_count_o (allocated_count_o),
    .init_done_i       (init_done),
    .committed_i       (committed),
    .cmd_o             (cmd),
    .rsp_i             (rsp),
    .push_i            (push),
    .penq_o            (penq)
  );

  ba_back #(.SLOT_CAPACITY(SLOT_CAPACITY), .PENDING_DEPTH(PENDING_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .penq_i      (penq),
    .rsp_o       (rsp),
    .push_o      (push),
    .init_done_o (init_done),
    .committed_o (committed)
  );

endmodule

// ----- hw/rtl/ba_checker.sv -----
module ba_checker import ba_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] slot_out_o,
  input logic [1:0]  status_o,
  input logic        bound_o,
  input logic [31:0] texture_out_o,
  input logic [31:0] sampler_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_out_o) && $stable(status_o))
    else $error("result dropped while stalled");

  a_nofree_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NO_FREE |-> slot_out_o == 12'd0)
    else $error("failed allocation returned a slot");

  a_bound_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bound_o |-> status_o == ST_OK && slot_out_o == 12'd0)
    else $error("bound set on a failed or non-lookup result");

  a_unbound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bound_o |-> texture_out_o == 32'd0 && sampler_out_o == 32'd0)
    else $error("handles shown without a binding");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind bindless_slot_allocator_deferred ba_checker u_ba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .slot_out_o    (slot_out_o),
  .status_o      (status_o),
  .bound_o       (bound_o),
  .texture_out_o (texture_out_o),
  .sampler_out_o (sampler_out_o)
);

// ----- tb/bindless_slot_allocator_deferred_tb.sv -----
module bindless_slot_allocator_deferred_tb;
  import ba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = 4096;
  localparam int unsigned Depth = 64;
  localparam longint unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] slot;
    logic [31:0] texture;
    logic [31:0] sampler;
  } req_t;

  typedef struct packed {
    logic [11:0] slot_out;
    logic [1:0]  status;
    logic        bound;
    logic [31:0] texture_out;
    logic [31:0] sampler_out;
    logic [11:0] allocated_count;
  } res_t;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] slot;
    logic [31:0] texture;
    logic [31:0] sampler;
  } pend_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [2:0] op_i;
  logic [11:0] slot_i;
  logic [31:0] texture_i, sampler_i;
  logic [11:0] slot_out_o, allocated_count_o;
  logic [1:0] status_o;
  logic bound_o;
  logic [31:0] texture_out_o, sampler_out_o;

  bindless_slot_allocator_deferred dut (.*);

  // predictor state
  int unsigned fresh_ptr;
  logic [11:0] free_slots[$];
  bit slot_live[Cap];
  bit slot_bound[Cap];
  logic [31:0] tex_tbl[Cap];
  logic [31:0] smp_tbl[Cap];
  pend_t pend_q[$];
  int unsigned live_count;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int unsigned send_idle_pct, recv_stall_pct;
  int errors;
  longint unsigned cycles = 0;
  int unsigned fresh_est;

  task automatic add_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic void commit_pending();
    foreach (pend_q[i]) begin
      case (pend_q[i].kind)
        KIND_ALLOC: if (!slot_live[pend_q[i].slot]) begin
          slot_live[pend_q[i].slot] = 1;
          live_count++;
        end
        KIND_UPDATE: if (slot_live[pend_q[i].slot]) begin
          tex_tbl[pend_q[i].slot] = pend_q[i].texture;
          smp_tbl[pend_q[i].slot] = pend_q[i].sampler;
          slot_bound[pend_q[i].slot] = 1;
        end
        KIND_FREE: if (slot_live[pend_q[i].slot]) begin
          slot_live[pend_q[i].slot] = 0;
          slot_bound[pend_q[i].slot] = 0;
          if (free_slots.size() < Cap) free_slots = {free_slots, pend_q[i].slot};
          if (live_count > 0) live_count--;
        end
        default: ;
      endcase
    end
    pend_q.delete();
  endfunction

  function automatic res_t predict_result(req_t r);
    res_t e;
    bit full;
    pend_t p;
    e = '0;
    full = pend_q.size() >= Depth;
    case (r.op)
      OP_ALLOC: begin
        if (full) e.status = ST_FULL;
        else if (free_slots.size() > 0) begin
          e.slot_out = free_slots[free_slots.size() - 1];
          free_slots.delete(free_slots.size() - 1);
        end
        else if (fresh_ptr >= Cap) e.status = ST_NO_FREE;
        else begin
          e.slot_out = fresh_ptr[11:0];
          fresh_ptr++;
        end
        if (e.status == ST_OK) begin
          p = '{KIND_ALLOC, e.slot_out, 32'd0, 32'd0};
          pend_q = {pend_q, p};
        end
      end
      OP_UPDATE, OP_FREE: begin
        if (r.slot == 0 || r.slot >= fresh_ptr) e.status = ST_INVALID;
        else if (full) e.status = ST_FULL;
        else begin
          if (r.op == OP_UPDATE) p = '{KIND_UPDATE, r.slot, r.texture, r.sampler};
          else p = '{KIND_FREE, r.slot, 32'd0, 32'd0};
          pend_q = {pend_q, p};
        end
      end
      OP_FLUSH: commit_pending();
      OP_LOOKUP: begin
        if (r.slot == 0) e.status = ST_INVALID;
        else if (slot_live[r.slot] && slot_bound[r.slot]) begin
          e.bound = 1;
          e.texture_out = tex_tbl[r.slot];
          e.sampler_out = smp_tbl[r.slot];
        end
      end
      default: e.status = ST_INVALID;
    endcase
    e.allocated_count = live_count[11:0];
    return e;
  endfunction

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= '0;
      slot_i <= '0;
      texture_i <= '0;
      sampler_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        expected_res = {expected_res,
                        predict_result(req_t'({op_i, slot_i, texture_i, sampler_i}))};
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_t r;
        r = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        op_i <= r.op;
        slot_i <= r.slot;
        texture_i <= r.texture;
        sampler_i <= r.sampler;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_res.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          res_t e;
          e = expected_res.pop_front();
          if (slot_out_o !== e.slot_out) begin
            $error("slot_out exp %0d got %0d", e.slot_out, slot_out_o); errors++;
          end
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o); errors++;
          end
          if (bound_o !== e.bound) begin
            $error("bound exp %0d got %0d", e.bound, bound_o); errors++;
          end
          if (texture_out_o !== e.texture_out) begin
            $error("texture_out exp %h got %h", e.texture_out, texture_out_o); errors++;
          end
          if (sampler_out_o !== e.sampler_out) begin
            $error("sampler_out exp %h got %h", e.sampler_out, sampler_out_o); errors++;
          end
          if (allocated_count_o !== e.allocated_count) begin
            $error("allocated_count exp %0d got %0d", e.allocated_count, allocated_count_o);
            errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic req_t rand_req(int unsigned mode);
    req_t r;
    int unsigned k;
    r.texture = $urandom();
    r.sampler = $urandom();
    k = $urandom_range(99);
    // mostly well-formed traffic on slots handed out so far
    if (k < 30) r.op = OP_ALLOC;
    else if (k < 55) r.op = OP_UPDATE;
    else if (k < 70) r.op = OP_FREE;
    else if (k < 77) r.op = OP_FLUSH;
    else if (k < 97) r.op = OP_LOOKUP;
    else r.op = 3'($urandom_range(7, 5));
    if (mode == 1 && r.op == OP_FREE) r.op = OP_ALLOC;
    if ($urandom_range(9) == 0) r.slot = 12'($urandom());
    else r.slot = 12'($urandom_range((fresh_est > 1) ? fresh_est - 1 : 1, 0));
    return r;
  endfunction

  task automatic run_phase(int unsigned n, int unsigned idle, int unsigned stall, int unsigned mode);
    req_t r;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int unsigned i = 0; i < n; i++) begin
      r = rand_req(mode);
      if (r.op == OP_ALLOC && fresh_est < Cap) fresh_est++;
      add_req(r);
    end
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_res.size() == 0);
  endtask

  initial begin
    req_t r;
    errors = 0;
    fresh_ptr = 1;
    fresh_est = 1;
    live_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and special cases
    add_req('{OP_LOOKUP, 12'd0, 32'd0, 32'd0});
    add_req('{OP_LOOKUP, 12'hfff, 32'd0, 32'd0});
    add_req('{OP_UPDATE, 12'd1, 32'hffffffff, 32'hffffffff});
    add_req('{OP_FREE, 12'd0, 32'd0, 32'd0});
    add_req('{OP_ALLOC, 12'd0, 32'd0, 32'd0});
    add_req('{OP_ALLOC, 12'd0, 32'd0, 32'd0});
    add_req('{OP_UPDATE, 12'd1, 32'hffffffff, 32'h0});
    add_req('{OP_UPDATE, 12'd2, 32'h0, 32'hffffffff});
    add_req('{OP_LOOKUP, 12'd1, 32'd0, 32'd0});
    add_req('{OP_FLUSH, 12'd0, 32'd0, 32'd0});
    add_req('{OP_LOOKUP, 12'd1, 32'd0, 32'd0});
    add_req('{OP_LOOKUP, 12'd2, 32'd0, 32'd0});
    add_req('{OP_FREE, 12'd1, 32'd0, 32'd0});
    add_req('{OP_UPDATE, 12'd3, 32'd5, 32'd6});
    add_req('{OP_FLUSH, 12'd0, 32'd0, 32'd0});
    add_req('{OP_LOOKUP, 12'd1, 32'd0, 32'd0});
    add_req('{OP_ALLOC, 12'd0, 32'd0, 32'd0});
    add_req('{3'd5, 12'd0, 32'd0, 32'd0});
    add_req('{3'd7, 12'hfff, 32'hffffffff, 32'hffffffff});
    add_req('{OP_FLUSH, 12'd0, 32'd0, 32'd0});
    fresh_est = 3;
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_res.size() == 0);

    // queue full: 65 updates without a flush
    for (int i = 0; i < 65; i++) begin
      r = '{OP_UPDATE, 12'd2, $urandom(), $urandom()};
      add_req(r);
    end
    add_req('{OP_ALLOC, 12'd0, 32'd0, 32'd0});
    add_req('{OP_FREE, 12'd2, 32'd0, 32'd0});
    add_req('{OP_FLUSH, 12'd0, 32'd0, 32'd0});
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_res.size() == 0);

    run_phase(200, 0, 0, 0);
    run_phase(200, 69, 0, 0);
    run_phase(200, 0, 69, 0);
    run_phase(200, 35, 35, 0);

    // allocate in bursts with periodic flushes
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 120; i++) begin
      if (i % 30 == 29) add_req('{OP_FLUSH, 12'd0, 32'd0, 32'd0});
      else begin
        add_req('{OP_ALLOC, 12'($urandom()), $urandom(), $urandom()});
        if (fresh_est < Cap) fresh_est++;
      end
    end
    add_req('{OP_FLUSH, 12'd0, 32'd0, 32'd0});
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_res.size() == 0);
    run_phase(150, 0, 0, 0);

    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
